### hw/rtl/scsa_pkg.sv
// ----------------------------------------------------------------------------
// Size-class slab allocator package
// Shared widths, status codes and operation codes of the slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

	localparam int ADDR_W       = 20;
	localparam int SIZE_W       = 20;
	localparam int STAT_W       = 2;
	localparam int LINK_AW      = ADDR_W - 3;
	localparam int LINK_DEPTH   = 1 << LINK_AW;
	localparam int HDR_BYTES    = 8;
	localparam int ADDR_SPACE   = 1 << ADDR_W;
	// Width of the block start plus header, the dividend of the padding remainder.
	localparam int DIV_W        = ADDR_W + 1;
	// Shift of the fixed-point reciprocal used to find the size class.
	localparam int CLS_RECIP_SH = 21;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NULL      = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

endpackage

### hw/rtl/size_class_slab_allocator_unit.sv
// ----------------------------------------------------------------------------
// Size-class slab allocator
// Segregated free-list allocator with one LIFO free list and one bump block
// per size class, backed by a class table and a link memory.
// ----------------------------------------------------------------------------
// A rejected request goes straight to S_OUT; a free or a bump allocation passes
// S_READ and S_EVAL, a free-list pop also S_POP, and a new heap block also S_DIV,
// S_PAD and S_CHK (the 21-step remainder unit computes the first-slot padding).
// One item is in flight at a time; the next item is accepted in the cycle after
// the result enters the output register. Reset empties every class and the heap
// at once through per-class valid bits; no clearing pass is needed.
module size_class_slab_allocator_unit #(
	parameter int NUM_CLASSES = 64,
	parameter int SLOT_STEP   = 8,
	parameter int BLOCK_BYTES = 4096,
	parameter int HEAP_BLOCKS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [scsa_pkg::SIZE_W-1:0]  request_size,
	input  logic [scsa_pkg::ADDR_W-1:0]  free_address,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [scsa_pkg::ADDR_W-1:0]  slot_address,
	output logic [scsa_pkg::STAT_W-1:0]  status
);
	import scsa_pkg::*;

	// Largest pooled size; sizes above it are rejected as too large.
	localparam int POOL_LIMIT = NUM_CLASSES * SLOT_STEP;
	localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	// Width of request_size - 1 for a pooled size.
	localparam int X_W        = $clog2(POOL_LIMIT);
	// Rounded-up reciprocal of the slot step. With x * SLOT_STEP below
	// 2**CLS_RECIP_SH the product gives the exact quotient.
	localparam int RECIP      = ((1 << CLS_RECIP_SH) + SLOT_STEP - 1) / SLOT_STEP;
	localparam int RECIP_W    = $clog2(RECIP + 1);
	localparam int PROD_W     = (X_W + RECIP_W > CLS_RECIP_SH + CLS_W) ?
	                            X_W + RECIP_W : CLS_RECIP_SH + CLS_W;
	localparam int SLOT_W     = $clog2(POOL_LIMIT + 1);
	localparam int BT_W       = $clog2(HEAP_BLOCKS + 1);
	// Wide enough for a block end plus a slot, past the top of the address space.
	localparam int SUM_W      = ADDR_W + 2;

	// One class table entry: free-list head (zero is empty), bump pointer and
	// end of the class's current block.
	typedef struct packed {
		logic [ADDR_W-1:0] head;
		logic [ADDR_W:0]   bump;
		logic [ADDR_W:0]   blk_end;
	} cls_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_POP,
		S_DIV,
		S_PAD,
		S_CHK,
		S_OUT
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CLS_W-1:0]    cls_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SUM_W-1:0]    first_q;
	logic [ADDR_W-1:0]   res_addr_q;
	status_t             res_status_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   slot_address_q;
	status_t             status_q;
	logic [BT_W-1:0]     blocks_taken_q;
	logic [ADDR_W:0]     heap_base_q;

	// ------------------------------------------------------------------
	// Request decode: class index and early rejection, straight from the
	// input ports while the block is idle.
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0]   size_dec;
	logic [X_W-1:0]      size_m1;
	logic [PROD_W-1:0]   cls_prod;
	logic [CLS_W-1:0]    cls_calc;
	status_t             size_status;
	status_t             pre_status;

	assign size_dec = request_size - SIZE_W'(1);
	assign size_m1  = size_dec[X_W-1:0];
	assign cls_prod = PROD_W'(size_m1) * PROD_W'(RECIP);
	assign cls_calc = cls_prod[CLS_RECIP_SH +: CLS_W];

	always_comb begin
		if (request_size == '0) begin
			size_status = ST_NULL;
		end else if (request_size > SIZE_W'(POOL_LIMIT)) begin
			size_status = ST_TOO_LARGE;
		end else begin
			size_status = ST_OK;
		end
		// A free of the null address is rejected before its size is looked at.
		if (op_t'(operation) == OP_FREE && free_address == '0) begin
			pre_status = ST_NULL;
		end else begin
			pre_status = size_status;
		end
	end

	// ------------------------------------------------------------------
	// Class table. Each entry has a valid bit that reset clears; an entry
	// that was never written reads as all zero (empty list, no block).
	// ------------------------------------------------------------------
	cls_entry_t          cls_mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] cls_vld_q;
	cls_entry_t          cls_rdata_q;
	logic                cls_rvld_q;
	cls_entry_t          ent;
	logic                cls_we;
	cls_entry_t          cls_wdata;

	always_ff @(posedge clk) begin
		if (cls_we) begin
			cls_mem[cls_q] <= cls_wdata;
		end
		cls_rdata_q <= cls_mem[cls_q];
		cls_rvld_q  <= cls_vld_q[cls_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_vld_q <= '0;
		end else if (cls_we) begin
			cls_vld_q[cls_q] <= 1'b1;
		end
	end

	assign ent = cls_rvld_q ? cls_rdata_q : '0;

	// ------------------------------------------------------------------
	// Link memory, indexed by byte address / 8. A free stores the old head
	// at the freed slot; a pop reads the link of the current head.
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0]   link_mem [LINK_DEPTH];
	logic [ADDR_W-1:0]   link_rdata_q;
	logic                link_we;

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[addr_q[ADDR_W-1 -: LINK_AW]] <= ent.head;
		end
		link_rdata_q <= link_mem[ent.head[ADDR_W-1 -: LINK_AW]];
	end

	// ------------------------------------------------------------------
	// Slot arithmetic.
	// ------------------------------------------------------------------
	logic [SLOT_W-1:0]   slot_calc;
	logic [SUM_W-1:0]    bump_sum;
	logic                bump_fits;
	logic [SUM_W-1:0]    hdr_addr;
	logic [SUM_W-1:0]    base_end;
	logic [SUM_W-1:0]    first_sum;
	logic                fit_fail;
	logic                exhausted;
	logic                div_start;
	logic                rem_done;
	logic [SLOT_W-1:0]   rem_val;
	logic [SLOT_W-1:0]   pad;

	assign slot_calc = SLOT_W'((int'(cls_q) + 1) * SLOT_STEP);
	assign bump_sum  = SUM_W'(ent.bump) + SUM_W'(slot_q);
	assign bump_fits = bump_sum <= SUM_W'(ent.blk_end);

	// A fresh block starts at heap_base_q; its first slot sits past the header,
	// rounded up to a multiple of the slot size.
	assign hdr_addr  = SUM_W'(heap_base_q) + SUM_W'(HDR_BYTES);
	assign base_end  = SUM_W'(heap_base_q) + SUM_W'(BLOCK_BYTES);
	assign pad       = (rem_val == '0) ? '0 : slot_q - rem_val;
	assign first_sum = first_q + SUM_W'(slot_q);
	assign fit_fail  = first_sum > base_end;
	assign exhausted = (blocks_taken_q >= BT_W'(HEAP_BLOCKS)) ||
	                   (base_end > SUM_W'(ADDR_SPACE));

	scsa_rem #(
		.DIVISOR_W (SLOT_W)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (hdr_addr[DIV_W-1:0]),
		.divisor   (slot_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// ------------------------------------------------------------------
	// Write-back decisions. All table writes for an item happen in its last
	// working state, so the next item's read always sees them.
	// ------------------------------------------------------------------
	always_comb begin
		cls_we    = 1'b0;
		cls_wdata = ent;
		link_we   = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			S_EVAL: begin
				if (op_q == OP_FREE) begin
					// Push: the freed slot links to the old head.
					cls_we         = 1'b1;
					link_we        = 1'b1;
					cls_wdata.head = addr_q;
				end else if (ent.head == '0) begin
					if (bump_fits) begin
						cls_we         = 1'b1;
						cls_wdata.bump = bump_sum[ADDR_W:0];
					end else begin
						div_start = 1'b1;
					end
				end
			end
			S_POP: begin
				cls_we         = 1'b1;
				cls_wdata.head = link_rdata_q;
			end
			S_CHK: begin
				if (!fit_fail && !exhausted) begin
					cls_we            = 1'b1;
					cls_wdata.bump    = first_sum[ADDR_W:0];
					cls_wdata.blk_end = base_end[ADDR_W:0];
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer and output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			out_valid_q    <= 1'b0;
			blocks_taken_q <= '0;
			heap_base_q    <= '0;
		end else begin
			// The consumer takes the waiting result. In S_OUT the load below
			// decides the output register on its own.
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= op_t'(operation);
						addr_q <= free_address;
						cls_q  <= cls_calc;
						if (pre_status != ST_OK) begin
							res_addr_q   <= '0;
							res_status_q <= pre_status;
							state_q      <= S_OUT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					slot_q  <= slot_calc;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					res_status_q <= ST_OK;
					if (op_q == OP_FREE) begin
						res_addr_q <= '0;
						state_q    <= S_OUT;
					end else if (ent.head != '0) begin
						state_q <= S_POP;
					end else if (bump_fits) begin
						res_addr_q <= ent.bump[ADDR_W-1:0];
						state_q    <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_POP: begin
					res_addr_q <= ent.head;
					state_q    <= S_OUT;
				end
				S_DIV: begin
					if (rem_done) begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					first_q <= hdr_addr + SUM_W'(pad);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (fit_fail) begin
						// The slot does not fit even in a fresh block.
						res_addr_q   <= '0;
						res_status_q <= ST_TOO_LARGE;
					end else if (exhausted) begin
						res_addr_q   <= '0;
						res_status_q <= ST_EXHAUSTED;
					end else begin
						res_addr_q     <= first_q[ADDR_W-1:0];
						res_status_q   <= ST_OK;
						blocks_taken_q <= blocks_taken_q + BT_W'(1);
						heap_base_q    <= base_end[ADDR_W:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						slot_address_q <= res_addr_q;
						status_q       <= res_status_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign slot_address = slot_address_q;
	assign status       = status_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A result only appears after the sequencer finished an item.
	a_out_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result shown without a finished item");

	// The next heap block always starts at blocks_taken * BLOCK_BYTES.
	a_heap_base: assert property (@(posedge clk) disable iff (!arst_n)
		32'(heap_base_q) == 32'(blocks_taken_q) * 32'(BLOCK_BYTES))
		else $error("heap base out of step with block count");

	// A class bump pointer never passes the end of its block.
	a_bump_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		cls_we |-> cls_wdata.bump <= cls_wdata.blk_end)
		else $error("bump pointer written past block end");

	// The remainder unit only finishes while the sequencer waits for it.
	a_rem_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == S_DIV)
		else $error("remainder finished outside its wait state");

endmodule

### hw/rtl/scsa_rem.sv
// ----------------------------------------------------------------------------
// Slab allocator remainder unit
// Restoring bit-serial remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module scsa_rem #(
	parameter int DIVISOR_W = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [scsa_pkg::DIV_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]        divisor,
	output logic                        done,
	output logic [DIVISOR_W-1:0]        remainder
);
	import scsa_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]     dvd_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [DIVISOR_W:0]   trial;
	logic                 take;
	logic [DIVISOR_W:0]   diff;

	// The partial remainder stays below the divisor, so it fits its width.
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign take  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
